FILE: hdl/tick_delay_wakeup_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tick delay wakeup table
// Shared shorthand for clocked concurrent checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef TICK_DELAY_WAKEUP_TABLE_DEFINES_SVH
`define TICK_DELAY_WAKEUP_TABLE_DEFINES_SVH

// Check that is switched off while reset is held.
`define TDWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds through reset.
`define TDWT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tdwt_pkg.sv
// ----------------------------------------------------------------------------
// tdwt_pkg
// Sizes, codes and cell interface types of the tick delay wakeup table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdwt_pkg;

  localparam int MAX_WAITERS  = 16;
  localparam int TASK_ID_BITS = 6;
  localparam int TICK_BITS    = 32;

  // request types
  localparam logic [1:0] REQ_TIME  = 2'd0;
  localparam logic [1:0] REQ_DELAY = 2'd1;
  localparam logic [1:0] REQ_UNTIL = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // reply kinds
  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [TASK_ID_BITS-1:0] caller;    // task of the current request
    logic [TICK_BITS-1:0]    wdata;     // deadline to store
    logic [TICK_BITS-1:0]    now;       // current tick count
    logic                    store_en;  // store request this cycle
    logic                    any_hit;   // some cell already holds caller
    logic                    tok_shift; // move scan token one cell down
  } tdwt_ctrl_t;

  // status from one cell back to the controller
  typedef struct packed {
    logic                    hit;      // valid entry owned by caller
    logic                    tok;      // scan token sits here
    logic                    fire;     // token here and deadline reached
    logic [TASK_ID_BITS-1:0] task_id;
    logic [TICK_BITS-1:0]    deadline;
  } tdwt_stat_t;

endpackage

FILE: hdl/tdwt_cell.sv
// ----------------------------------------------------------------------------
// tdwt_cell
// One slot of the wakeup table: entry storage, free-slot claim chain link
// and one stage of the scan token line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdwt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tdwt_pkg::tdwt_ctrl_t ctrl,
  input  logic               claim_in,   // a free slot exists below
  output logic               claim_out,  // a free slot exists here or below
  input  logic               tok_in,     // token from the cell above
  output tdwt_pkg::tdwt_stat_t stat
);
  import tdwt_pkg::*;

  logic                    valid_r,    valid_nxt;
  logic                    tok_r,      tok_nxt;
  logic [TASK_ID_BITS-1:0] task_r,     task_nxt;
  logic [TICK_BITS-1:0]    deadline_r, deadline_nxt;
  logic                    hit;
  logic                    take;
  logic                    fire;

  assign hit       = valid_r && (task_r == ctrl.caller);
  assign take      = !valid_r && !claim_in;
  assign claim_out = claim_in || !valid_r;
  assign fire      = tok_r && valid_r && (deadline_r == ctrl.now);

  always_comb begin
    valid_nxt    = valid_r;
    task_nxt     = task_r;
    deadline_nxt = deadline_r;
    tok_nxt      = tok_r;
    if (ctrl.store_en) begin
      if (ctrl.any_hit) begin
        if (hit) begin
          deadline_nxt = ctrl.wdata;
        end
      end else if (take) begin
        valid_nxt    = 1'b1;
        task_nxt     = ctrl.caller;
        deadline_nxt = ctrl.wdata;
      end
    end
    if (ctrl.tok_shift) begin
      tok_nxt = tok_in;
      // released as the token leaves
      if (fire) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    task_r     <= task_nxt;
    deadline_r <= deadline_nxt;
  end

  assign stat.hit      = hit;
  assign stat.tok      = tok_r;
  assign stat.fire     = fire;
  assign stat.task_id  = task_r;
  assign stat.deadline = deadline_r;

endmodule

FILE: hdl/tick_delay_wakeup_table.sv
// ----------------------------------------------------------------------------
// tick_delay_wakeup_table
// Tick counter and sleeping-caller table built as a row of slot cells.
// ----------------------------------------------------------------------------
// Time, delay and until requests are latched, then stored or answered in S_DECIDE
// through the reply register. Tick: S_DECIDE starts it, then the scan token walks
// the 16 cells from top to bottom (S_SCAN), then S_FINAL gives the ticker reply.
// Throughput: one request at a time; ticks hold the input through the scan plus
// any output stall. Reset (synchronous, rst_n low) clears the count and the
// table directly; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_delay_wakeup_table (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic [tdwt_pkg::TASK_ID_BITS-1:0] in_caller_id,
  input  logic [tdwt_pkg::TICK_BITS-1:0]    in_tick_arg,
  // reply channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tdwt_pkg::TASK_ID_BITS-1:0] out_reply_to,
  output logic [1:0]                        out_reply_kind,
  output logic [tdwt_pkg::TICK_BITS-1:0]    out_reply_value,
  output logic                              out_last
);
  import tdwt_pkg::*;

  `include "tick_delay_wakeup_table_defines.svh"

  // controller states
  localparam logic [1:0] S_IDLE   = 2'd0;  // waiting for a request
  localparam logic [1:0] S_DECIDE = 2'd1;  // classify request, store or reply
  localparam logic [1:0] S_SCAN   = 2'd2;  // token walks the cells
  localparam logic [1:0] S_FINAL  = 2'd3;  // empty reply to the ticker

  logic [1:0]              state_r, state_nxt;
  logic [TICK_BITS-1:0]    now_r, now_nxt;

  // latched request
  logic [1:0]              req_type_r;
  logic [TASK_ID_BITS-1:0] req_caller_r;
  logic [TICK_BITS-1:0]    req_arg_r;

  // reply register, parts the reply channel from the controller
  logic                    out_valid_r, out_valid_nxt;
  logic [TASK_ID_BITS-1:0] out_to_r, out_to_nxt;
  logic [1:0]              out_kind_r, out_kind_nxt;
  logic [TICK_BITS-1:0]    out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_free;

  // cell row
  tdwt_ctrl_t              ctrl;
  tdwt_stat_t              stat    [MAX_WAITERS];
  logic [MAX_WAITERS-1:0]  claim_out;
  logic [MAX_WAITERS-1:0]  tok_vec;
  logic                    top_tok;

  // reductions over the row
  logic                    any_hit;
  logic                    any_free;
  logic                    cur_fire;
  logic [TASK_ID_BITS-1:0] fire_task;
  logic [TICK_BITS-1:0]    fire_deadline;

  logic                    in_accept;
  logic [TICK_BITS-1:0]    rel_deadline;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign rel_deadline = now_r + req_arg_r;  // wraps at 32 bits

  // --------------------------------------------------------------------------
  // Slot cells. The claim chain runs upward so the lowest free slot wins; the
  // scan token runs downward so slots are released high to low.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    logic claim_in;
    logic tok_in;
    if (i == 0) begin : g_bot
      assign claim_in = 1'b0;
    end else begin : g_mid
      assign claim_in = claim_out[i-1];
    end
    if (i == MAX_WAITERS - 1) begin : g_top
      assign tok_in = top_tok;
    end else begin : g_low
      assign tok_in = tok_vec[i+1];
    end

    tdwt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .claim_in  (claim_in),
      .claim_out (claim_out[i]),
      .tok_in    (tok_in),
      .stat      (stat[i])
    );

    assign tok_vec[i] = stat[i].tok;
  end

  assign any_free = claim_out[MAX_WAITERS-1];

  // At most one cell holds the token, so an OR picks its entry.
  always_comb begin
    any_hit       = 1'b0;
    cur_fire      = 1'b0;
    fire_task     = '0;
    fire_deadline = '0;
    for (int i = 0; i < MAX_WAITERS; i++) begin
      any_hit = any_hit | stat[i].hit;
      if (stat[i].fire) begin
        cur_fire      = 1'b1;
        fire_task     = fire_task | stat[i].task_id;
        fire_deadline = fire_deadline | stat[i].deadline;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    logic                 need_reply;
    logic [1:0]           kind;
    logic [TICK_BITS-1:0] value;
    logic                 want_store;

    need_reply = 1'b0;
    kind       = KIND_NUMBER;
    value      = '0;
    want_store = 1'b0;

    state_nxt     = state_r;
    now_nxt       = now_r;
    top_tok       = 1'b0;

    ctrl.caller    = req_caller_r;
    ctrl.wdata     = (req_type_r == REQ_DELAY) ? rel_deadline : req_arg_r;
    ctrl.now       = now_r;
    ctrl.store_en  = 1'b0;
    ctrl.any_hit   = any_hit;
    ctrl.tok_shift = 1'b0;

    // reply register drains on its own
    out_valid_nxt = out_valid_r && out_stall;
    out_to_nxt    = out_to_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (req_type_r)
          REQ_TIME: begin
            need_reply = 1'b1;
            value      = now_r;
          end
          REQ_DELAY: begin
            if (req_arg_r == '0) begin
              need_reply = 1'b1;
              value      = now_r;
            end else begin
              want_store = 1'b1;
            end
          end
          REQ_UNTIL: begin
            if (req_arg_r < now_r) begin
              need_reply = 1'b1;
              kind       = KIND_EMPTY;
            end else if (req_arg_r == now_r) begin
              need_reply = 1'b1;
              value      = now_r;
            end else begin
              want_store = 1'b1;
            end
          end
          default: begin
            // tick: bump the count and drop the token into the top cell
            now_nxt        = now_r + 32'd1;
            ctrl.tok_shift = 1'b1;
            top_tok        = 1'b1;
            state_nxt      = S_SCAN;
          end
        endcase

        if (want_store) begin
          if (any_hit || any_free) begin
            ctrl.store_en = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            need_reply = 1'b1;
            kind       = KIND_FULL;
          end
        end

        if (need_reply && out_free) begin
          out_valid_nxt = 1'b1;
          out_to_nxt    = req_caller_r;
          out_kind_nxt  = kind;
          out_value_nxt = value;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_SCAN: begin
        // a due slot holds the token until its reply fits
        if (!cur_fire || out_free) begin
          ctrl.tok_shift = 1'b1;
          if (cur_fire) begin
            out_valid_nxt = 1'b1;
            out_to_nxt    = fire_task;
            out_kind_nxt  = KIND_NUMBER;
            out_value_nxt = fire_deadline;
            out_last_nxt  = 1'b0;
          end
          if (tok_vec[0]) begin
            state_nxt = S_FINAL;
          end
        end
      end

      default: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_to_nxt    = req_caller_r;
          out_kind_nxt  = KIND_EMPTY;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_type_r   <= in_req_type;
      req_caller_r <= in_caller_id;
      req_arg_r    <= in_tick_arg;
    end
    out_to_r    <= out_to_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_reply_to    = out_to_r;
  assign out_reply_kind  = out_kind_r;
  assign out_reply_value = out_value_r;
  assign out_last        = out_last_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `TDWT_ASSERT(a_tok_onehot0, ($onehot0(tok_vec)), "more than one scan token")
  `TDWT_ASSERT(a_scan_has_tok, ((state_r == S_SCAN) |-> (tok_vec != '0)), "scan lost token")
  `TDWT_ASSERT(a_idle_no_tok, ((state_r != S_SCAN) |-> (tok_vec == '0)), "stray scan token")
  `TDWT_ASSERT(a_tick_inc, ((state_r == S_DECIDE && req_type_r == REQ_TICK) |=> (now_r == $past(now_r) + 32'd1)), "tick count not advanced")

endmodule

FILE: tb/tick_delay_wakeup_table_test.sv
`timescale 1ns / 1ps
// ============================================================================
// tick_delay_wakeup_table_test
// Self-checking bench for the tick-driven sleep/wakeup table.
// A queue of planned requests feeds a bursty request driver. A monitor keeps
// its own copy of the tick count and sleeper slots, predicts every reply, and
// checks the reply stream in order while the reply side stalls on a pattern.
// ============================================================================
module tick_delay_wakeup_table_test;
  import tdwt_pkg::*;

  localparam int RANDOM_ITEMS = 440;   // on top of the directed opening
  localparam int POOL_TOP     = 23;    // busy callers, enough to overflow 16 slots
  localparam int IDLE_LIMIT   = 1000;  // a tick holds the input through a full scan, stalls are capped
  localparam int DRAIN_CYCLES = 40;    // > one full tick scan
  localparam int MAX_REPORTS  = 10;
  localparam int STALL_CAP    = 12;    // longest run of back-to-back stalls

  typedef struct {
    logic [1:0]              req_type;
    logic [TASK_ID_BITS-1:0] caller;
    logic [TICK_BITS-1:0]    arg;
  } sleep_req_t;

  typedef struct {
    logic [TASK_ID_BITS-1:0] dest;
    logic [1:0]              kind;
    logic [TICK_BITS-1:0]    value;
    logic                    last;
  } wake_reply_t;

  // reply-side stall styles
  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BEAT} flow_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_req_type = REQ_TIME;
  logic [TASK_ID_BITS-1:0] in_caller_id = '0;
  logic [TICK_BITS-1:0]    in_tick_arg = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TASK_ID_BITS-1:0] out_reply_to;
  logic [1:0]              out_reply_kind;
  logic [TICK_BITS-1:0]    out_reply_value;
  logic                    out_last;

  // planned requests, filled up front, drained by the driver
  sleep_req_t  planned_reqs[$];
  // replies predicted but not yet seen
  wake_reply_t awaited_replies[$];

  // monitor's own view of the block
  logic [TICK_BITS-1:0]    sleep_now;
  logic                    sleeper_busy[MAX_WAITERS];
  logic [TASK_ID_BITS-1:0] sleeper_task[MAX_WAITERS];
  logic [TICK_BITS-1:0]    sleeper_due[MAX_WAITERS];

  // planning side tracks the count the block will have when each request lands
  logic [TICK_BITS-1:0] plan_now = '0;
  int plan_count = 0;

  int error_count = 0;
  int reqs_taken = 0;
  int ticks_taken = 0;
  int replies_taken = 0;
  int wakeups_seen = 0;
  int full_seen = 0;
  int widest_tick = 0;
  int idle_cycles = 0;

  // driver / receiver pacing
  int         burst_left = 0;
  int         gap_left = 0;
  flow_mode_t flow_mode = FLOW_FREE;
  int         flow_age = 0;
  int         flow_step = 0;
  int         stall_run = 0;

  tick_delay_wakeup_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_caller_id   (in_caller_id),
    .in_tick_arg    (in_tick_arg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reply_to   (out_reply_to),
    .out_reply_kind (out_reply_kind),
    .out_reply_value(out_reply_value),
    .out_last       (out_last)
  );

  always #10 clk = ~clk;

  // Queue one request for the driver. Keeps plan_now in step so that
  // "until" deadlines can be aimed relative to the count at acceptance.
  task automatic queue_request(input logic [1:0] kind, input int unsigned caller,
                               input logic [TICK_BITS-1:0] arg);
    sleep_req_t r;
    r.req_type = kind;
    r.caller   = TASK_ID_BITS'(caller);
    r.arg      = arg;
    planned_reqs.push_back(r);
    plan_count++;
    if (kind == REQ_TICK) plan_now++;
  endtask

  // Work out the replies one accepted request causes and update the
  // shadow table. Stored deadlines cause no reply at all.
  task automatic predict_replies(input sleep_req_t r);
    wake_reply_t          batch[$];
    logic [TICK_BITS-1:0] deadline;
    int                   owner_slot;
    int                   free_slot;
    int                   s;
    owner_slot = -1;
    free_slot  = -1;
    case (r.req_type)
      REQ_TIME: batch.push_back('{r.caller, KIND_NUMBER, sleep_now, 1'b0});
      REQ_DELAY, REQ_UNTIL: begin
        deadline = (r.req_type == REQ_DELAY) ? sleep_now + r.arg : r.arg;
        if (r.req_type == REQ_UNTIL && r.arg < sleep_now) begin
          batch.push_back('{r.caller, KIND_EMPTY, '0, 1'b0});
        end else if (deadline == sleep_now) begin
          // zero delay or "until now": answer at once, table untouched
          batch.push_back('{r.caller, KIND_NUMBER, sleep_now, 1'b0});
        end else begin
          // walking down leaves the lowest free slot in free_slot
          for (s = MAX_WAITERS - 1; s >= 0; s--) begin
            if (sleeper_busy[s] && sleeper_task[s] == r.caller) owner_slot = s;
            if (!sleeper_busy[s]) free_slot = s;
          end
          if (owner_slot >= 0) begin
            sleeper_due[owner_slot] = deadline;
          end else if (free_slot < 0) begin
            batch.push_back('{r.caller, KIND_FULL, '0, 1'b0});
            full_seen++;
          end else begin
            sleeper_busy[free_slot] = 1'b1;
            sleeper_task[free_slot] = r.caller;
            sleeper_due[free_slot]  = deadline;
          end
        end
      end
      default: begin
        sleep_now++;
        // release order is top slot first
        for (s = MAX_WAITERS - 1; s >= 0; s--) begin
          if (sleeper_busy[s] && sleeper_due[s] == sleep_now) begin
            batch.push_back('{sleeper_task[s], KIND_NUMBER, sleeper_due[s], 1'b0});
            sleeper_busy[s] = 1'b0;
            wakeups_seen++;
          end
        end
        batch.push_back('{r.caller, KIND_EMPTY, '0, 1'b0});
        if (batch.size() > widest_tick) widest_tick = batch.size();
        ticks_taken++;
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) awaited_replies.push_back(batch[k]);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps in between, and a
  // request held steady while the block stalls it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    sleep_req_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (planned_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        nxt = planned_reqs.pop_front();
        in_valid     <= 1'b1;
        in_req_type  <= nxt.req_type;
        in_caller_id <= nxt.caller;
        in_tick_arg  <= nxt.arg;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // a quarter of bursts run straight into the next one
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Reply receiver: the stall style is redrawn when its random age runs out;
  // free-flowing stretches, light and heavy random stalls, and a fixed beat. Long
  // stall runs are cut short so the watchdog bound stays meaningful.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : stall_replies
    logic hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      flow_age  = 0;
      stall_run = 0;
    end else begin
      if (flow_age == 0) begin
        flow_mode = flow_mode_t'($urandom_range(0, 3));
        flow_age  = $urandom_range(20, 80);
      end else begin
        flow_age--;
      end
      case (flow_mode)
        FLOW_FREE:  hold = 1'b0;
        FLOW_LIGHT: hold = ($urandom_range(0, 3) == 0);
        FLOW_HEAVY: hold = ($urandom_range(0, 9) < 7);
        default:    hold = ((flow_step % 5) < 2);
      endcase
      flow_step++;
      if (stall_run >= STALL_CAP) hold = 1'b0;
      stall_run = hold ? stall_run + 1 : 0;
      out_stall <= hold;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted reply against the oldest prediction, then
  // predicts for any request accepted on the same edge. A reply can never
  // come from a request accepted on the same edge, so the order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_traffic
    wake_reply_t want;
    int s;
    if (!rst_n) begin
      sleep_now = '0;
      for (s = 0; s < MAX_WAITERS; s++) begin
        sleeper_busy[s] = 1'b0;
        sleeper_task[s] = '0;
        sleeper_due[s]  = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        replies_taken++;
        if (awaited_replies.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected reply to=%0d kind=%0d value=%h last=%0d", $realtime,
                     out_reply_to, out_reply_kind, out_reply_value, out_last);
        end else begin
          want = awaited_replies.pop_front();
          if (out_reply_to !== want.dest || out_reply_kind !== want.kind ||
              out_reply_value !== want.value || out_last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: reply mismatch: want to=%0d kind=%0d value=%h last=%0d, got to=%0d kind=%0d value=%h last=%0d",
                       $realtime, want.dest, want.kind, want.value, want.last,
                       out_reply_to, out_reply_kind, out_reply_value, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        reqs_taken++;
        predict_replies('{in_req_type, in_caller_id, in_tick_arg});
      end
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d replies still owed",
               IDLE_LIMIT, awaited_replies.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan and end of run
  // --------------------------------------------------------------------------
  initial begin : plan_and_finish
    int                   i;
    int                   roll;
    int                   shape;
    int                   span;
    int                   base;
    int unsigned          who;
    logic                 wide;
    logic [TICK_BITS-1:0] arg;

    // Directed opening. Count goes 0 -> 1 -> 2 -> 5 here.
    queue_request(REQ_TIME, 0, 32'hFFFF_FFFF);    // args ignored on a query
    queue_request(REQ_TICK, 63, 32'hFFFF_FFFF);   // now 1
    queue_request(REQ_DELAY, 5, 0);               // zero delay answers now
    queue_request(REQ_UNTIL, 6, 0);               // deadline passed: empty reply
    queue_request(REQ_UNTIL, 7, 1);               // deadline is now: answers now
    queue_request(REQ_DELAY, 10, 1);              // sleeps until 2, slot 0
    queue_request(REQ_DELAY, 20, 32'hFFFF_FFFF);  // sum wraps to 0, still stored
    queue_request(REQ_UNTIL, 21, 32'hFFFF_FFFF);  // far deadline
    queue_request(REQ_UNTIL, 13, 2);              // sleeps until 2, slot 3
    queue_request(REQ_TICK, 1, 0);                // now 2: wakes 13 then 10
    // 20 and 21 get overwritten, the other 14 take every remaining slot
    for (i = 20; i < 36; i++) queue_request(REQ_DELAY, i, 3);
    queue_request(REQ_DELAY, 40, 1);              // no room: table-full error
    // third tick releases all sixteen sleepers plus the ticker reply
    repeat (3) queue_request(REQ_TICK, 2, 0);

    // Random part: mostly single requests from a small set of callers so
    // overwrites and full-table errors keep happening, mixed with tick
    // runs and occasional groups that all sleep to the same deadline.
    while (plan_count < 30 + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll < 12) begin
        // wide callers only sleep briefly so stray ids never clog the table
        wide  = ($urandom_range(0, 4) == 0);
        who   = wide ? $urandom_range(0, 63) : $urandom_range(0, POOL_TOP);
        shape = $urandom_range(0, 9);
        roll  = $urandom_range(0, 99);
        if (roll < 15) begin
          queue_request(REQ_TIME, who, $urandom);
        end else if (roll < 50) begin
          if (wide || shape > 2) arg = $urandom_range(1, 12);
          else if (shape == 0)   arg = '0;
          else                   arg = $urandom;
          queue_request(REQ_DELAY, who, arg);
        end else if (roll < 75) begin
          if (shape < 2)                arg = plan_now;
          else if (shape == 2)          arg = (plan_now == 0) ? plan_now
                                            : plan_now - $urandom_range(1, plan_now);
          else if (shape == 3 && !wide) arg = $urandom;
          else                          arg = plan_now + $urandom_range(1, 12);
          queue_request(REQ_UNTIL, who, arg);
        end else begin
          queue_request(REQ_TICK, who, $urandom);
        end
      end else if (roll < 16) begin
        repeat ($urandom_range(2, 8)) queue_request(REQ_TICK, $urandom_range(0, 63), $urandom);
      end else if (roll < 19) begin
        queue_request(REQ_TIME, $urandom_range(0, 63), $urandom);
      end else begin
        // sixteen distinct callers, one shared deadline, then tick up to it
        span = $urandom_range(1, 6);
        base = $urandom_range(0, 63);
        for (i = 0; i < MAX_WAITERS; i++) begin
          who = (base + i) % (1 << TASK_ID_BITS);
          if ($urandom_range(0, 1) == 0) queue_request(REQ_DELAY, who, span);
          else                           queue_request(REQ_UNTIL, who, plan_now + span);
        end
        repeat (span) queue_request(REQ_TICK, $urandom_range(0, 63), $urandom);
      end
    end

    // single reset at the start of the run
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // everything handed over, then everything answered, then a quiet spell
    while (planned_reqs.size() != 0 || in_valid) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += awaited_replies.size();

    $display("Ran %0d requests (%0d ticks), checked %0d replies", reqs_taken, ticks_taken,
             replies_taken);
    $display("%0d wakeups, %0d table-full errors, up to %0d replies from one tick",
             wakeups_seen, full_seen, widest_tick);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d errors", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tdwt_pkg.sv
hdl/tdwt_cell.sv
hdl/tick_delay_wakeup_table.sv
tb/tick_delay_wakeup_table_test.sv
